[hdl/gcdfs_pkg.sv]
// Shared types and constants of the graph connectivity checker.
package gcdfs_pkg;

  localparam int MaxVerticesDef = 64;

  localparam int FuncW   = 2;
  localparam int VtxW    = 6;
  localparam int NumVtxW = 7;
  localparam int CountW  = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CHECK = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_INIT,
    S_POP,
    S_ROW,
    S_MASK,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic load_item;
    logic clr_wr;
    logic add_rd;
    logic add_wr;
    logic walk_init;
    logic pop;
    logic row_rd;
    logic mask;
    logic push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stack_empty;
    logic pend_empty;
    logic out_free;
  } status_t;

endpackage

[hdl/gcdfs_if.sv]
// Valid/ready channel interfaces for operation beats and result beats.
interface gcdfs_in_if;
  import gcdfs_pkg::*;

  logic            valid;
  logic            ready;
  logic [FuncW-1:0] func;
  logic [VtxW-1:0]  from_vertex;
  logic [VtxW-1:0]  to_vertex;

  modport source (output valid, output func, output from_vertex, output to_vertex,
                  input ready);
  modport sink   (input valid, input func, input from_vertex, input to_vertex,
                  output ready);
endinterface

interface gcdfs_out_if;
  import gcdfs_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_connected;
  logic [CountW-1:0] reached_count;

  modport source (output valid, output is_connected, output reached_count, input ready);
  modport sink   (input valid, input is_connected, input reached_count, output ready);
endinterface

[hdl/gcdfs_datapath.sv]
// Adjacency memory, walk stack, visited marks and result register.
module gcdfs_datapath #(
  parameter int MaxVertices = gcdfs_pkg::MaxVerticesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gcdfs_pkg::NumVtxW-1:0]  cfg_wdata_i,
  input  logic [gcdfs_pkg::VtxW-1:0]     from_vertex_i,
  input  logic [gcdfs_pkg::VtxW-1:0]     to_vertex_i,
  input  gcdfs_pkg::cmd_t                cmd_i,
  output gcdfs_pkg::status_t             status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           is_connected_o,
  output logic [gcdfs_pkg::CountW-1:0]   reached_count_o
);
  import gcdfs_pkg::*;

  localparam int VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);

  typedef logic [MaxVertices-1:0] row_t;

  // Storage.
  row_t           adj_mem   [MaxVertices];
  logic [VW-1:0]  stack_mem [MaxVertices];

  logic [NumVtxW-1:0] nv_q;
  logic [VW-1:0]      from_q, to_q;
  logic               add_ok_q;
  logic [VW-1:0]      clr_cnt_q;
  row_t               row_q;
  row_t               visited_q, visited_d;
  row_t               pend_q, pend_d;
  logic [VW-1:0]      stk_rd_q;
  logic [CW-1:0]      top_q, top_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q;
  logic               is_conn_q;
  logic [CountW-1:0]  rcount_q;

  logic [CW-1:0]      n_use;
  row_t               use_mask;
  row_t               new_mask;
  logic [VW-1:0]      low_idx;
  logic [CW-1:0]      top_dec;

  logic               adj_we;
  logic [VW-1:0]      adj_waddr;
  row_t               adj_wdata;
  logic [VW-1:0]      adj_raddr;
  logic               adj_re;
  logic               stk_we;
  logic [VW-1:0]      stk_waddr;
  logic [VW-1:0]      stk_wdata;

  // Vertex count in use: zero counts as one, and it never exceeds the storage.
  always_comb begin
    if (nv_q == '0) begin
      n_use = CW'(1);
    end else if (32'(nv_q) > 32'(MaxVertices)) begin
      n_use = CW'(MaxVertices);
    end else begin
      n_use = CW'(nv_q);
    end
    for (int u = 0; u < MaxVertices; u++) begin
      use_mask[u] = (32'(u) < 32'(n_use));
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (pend_q[i]) low_idx = VW'(i);
    end
  end

  assign new_mask = row_q & ~visited_q & use_mask;
  assign top_dec  = top_q - CW'(1);

  // Memory port selection.
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = clr_cnt_q;
    adj_wdata = '0;
    if (cmd_i.clr_wr) begin
      adj_we = 1'b1;
    end else if (cmd_i.add_wr && add_ok_q) begin
      adj_we    = 1'b1;
      adj_waddr = from_q;
      adj_wdata = row_q | (row_t'(1) << to_q);
    end
    adj_re    = cmd_i.add_rd | cmd_i.row_rd;
    adj_raddr = cmd_i.add_rd ? from_q : stk_rd_q;

    stk_we    = cmd_i.walk_init | cmd_i.push;
    stk_waddr = cmd_i.walk_init ? '0 : top_q[VW-1:0];
    stk_wdata = cmd_i.walk_init ? '0 : low_idx;
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) row_q <= adj_mem[adj_raddr];
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (cmd_i.pop) stk_rd_q <= stack_mem[top_dec[VW-1:0]];
  end

  // Walk bookkeeping.
  always_comb begin
    visited_d = visited_q;
    pend_d    = pend_q;
    top_d     = top_q;
    count_d   = count_q;
    if (cmd_i.clr_wr) begin
      visited_d = '0;
    end
    if (cmd_i.walk_init) begin
      visited_d = row_t'(1);
      top_d     = CW'(1);
      count_d   = CW'(1);
    end
    if (cmd_i.pop) begin
      top_d = top_dec;
    end
    if (cmd_i.mask) begin
      pend_d    = new_mask;
      visited_d = visited_q | new_mask;
    end
    if (cmd_i.push) begin
      pend_d  = pend_q & (pend_q - row_t'(1));
      top_d   = top_q + CW'(1);
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q        <= NumVtxW'(1);
      clr_cnt_q   <= '0;
      visited_q   <= '0;
      pend_q      <= '0;
      top_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) nv_q <= cfg_wdata_i;
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + VW'(1);
      end
      visited_q <= visited_d;
      pend_q    <= pend_d;
      top_q     <= top_d;
      count_q   <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      from_q   <= VW'(from_vertex_i);
      to_q     <= VW'(to_vertex_i);
      add_ok_q <= (32'(from_vertex_i) < 32'(MaxVertices)) &&
                  (32'(to_vertex_i) < 32'(MaxVertices));
    end
    if (cmd_i.out_load) begin
      is_conn_q <= (count_q == n_use);
      rcount_q  <= CountW'(count_q);
    end
  end

  assign status_o.clr_last    = (clr_cnt_q == VW'(MaxVertices - 1));
  assign status_o.stack_empty = (top_q == '0);
  assign status_o.pend_empty  = (pend_q == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign is_connected_o  = is_conn_q;
  assign reached_count_o = rcount_q;

  // Each vertex is pushed once at most, so the stack cannot overrun.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= 32'(MaxVertices))
    else $error("walk stack pointer beyond its depth");

  // Vertices waiting to be pushed are already marked visited.
  a_pend_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~visited_q) == '0)
    else $error("pending vertex without visited mark");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q == $past(count_q) + CW'(1)) && (top_q == $past(top_q) + CW'(1)))
    else $error("push did not advance reached count and stack pointer together");

endmodule

[hdl/gcdfs_ctrl.sv]
// Sequencer for clearing, neighbour insertion and the depth-first walk.
module gcdfs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [gcdfs_pkg::FuncW-1:0]  func_i,
  output logic                         in_ready_o,
  input  gcdfs_pkg::status_t           status_i,
  output gcdfs_pkg::cmd_t              cmd_o
);
  import gcdfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          case (func_e'(func_i))
            FUNC_ADD:   state_d = S_ADD_RD;
            FUNC_CHECK: state_d = S_INIT;
            FUNC_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_POP;
      end
      S_POP: begin
        // An empty stack ends the walk once the result register can take the beat.
        if (status_i.stack_empty) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d      = S_MASK;
      end
      S_MASK: begin
        cmd_o.mask = 1'b1;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        if (status_i.pend_empty) begin
          state_d = S_POP;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded while the result register is still held");

endmodule

[hdl/graph_connectivity_dfs.sv]
// Graph connectivity checker: top level joining the sequencer and the datapath.
//
// Operation beats arrive on in_i (func, from_vertex, to_vertex). func 0 sets
// bit to_vertex in the adjacency row of from_vertex, func 1 runs a depth-first
// walk from vertex 0 and returns one result beat on out_o (is_connected,
// reached_count), func 2 clears the graph, func 3 is dropped. num_vertices is
// written through cfg_we_i/cfg_wdata_i, and the user must write it only while
// the block is idle; the block leaves this check to the user. In a check, each
// popped vertex costs a registered stack read, a registered adjacency row read,
// a mask step and an empty test, and pushes leave one at a time through the
// lowest-set-bit encoder. One beat is worked on at a time; in_i.ready is high
// only between operations. Clearing walks the adjacency memory one row per
// cycle; the same pass runs straight after reset, during which no beat is
// taken. A result waits in its output register while out_o is stalled; the
// next operation is still taken, and a following check holds its result back
// only until that register is free.
module graph_connectivity_dfs #(
  parameter int MaxVertices = gcdfs_pkg::MaxVerticesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gcdfs_pkg::NumVtxW-1:0] cfg_wdata_i,
  gcdfs_in_if.sink                      in_i,
  gcdfs_out_if.source                   out_o
);
  import gcdfs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  gcdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  gcdfs_datapath #(
    .MaxVertices (MaxVertices)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .from_vertex_i   (in_i.from_vertex),
    .to_vertex_i     (in_i.to_vertex),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .is_connected_o  (out_o.is_connected),
    .reached_count_o (out_o.reached_count)
  );

endmodule
